>>> src/attribute_video_pixel_generator_unit_macros.svh
// assertion macros for the attribute video pixel generator
`ifndef ATTRIBUTE_VIDEO_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define ATTRIBUTE_VIDEO_PIXEL_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define AVPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AVPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/avpg_pkg.sv
// package: types, register codes and color tables of the pixel generator
package avpg_pkg;

	typedef struct packed {
		logic [7:0] video_byte;
		logic [7:0] paired_byte;
	} byte_item_t;

	typedef struct packed {
		logic [3:0] color_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_item_t;

	typedef enum logic [2:0] {
		CFG_COLOR_PROFILE = 3'd0,
		CFG_WIDE_MODE     = 3'd1,
		CFG_BLINK_PHASE   = 3'd2,
		CFG_USER_COLOR_0  = 3'd3,
		CFG_USER_COLOR_1  = 3'd4,
		CFG_USER_COLOR_2  = 3'd5,
		CFG_USER_COLOR_3  = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PROF_MONO     = 2'd0,
		PROF_STANDARD = 2'd1,
		PROF_USER     = 2'd2,
		PROF_EIGHT    = 2'd3
	} profile_t;

	typedef struct packed {
		profile_t        color_profile;
		logic            wide_mode;
		logic            blink_phase;
		logic [3:0][3:0] user_color;
	} cfg_t;

	typedef struct packed {
		logic [3:0] color_index;
		logic       last_pixel;
	} pix_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int CNT_W      = 3;

	localparam logic [3:0] COLOR_BLACK  = 4'd0;
	localparam logic [3:0] COLOR_SILVER = 4'd8;
	localparam logic [3:0] COLOR_WHITE  = 4'd15;

	localparam logic [CNT_W-1:0] LAST_NARROW = 3'd5;
	localparam logic [CNT_W-1:0] LAST_WIDE   = 3'd7;

	localparam profile_t   RST_PROFILE    = PROF_STANDARD;
	localparam logic [3:0] RST_USER_COLOR = 4'd15;

	function automatic logic [3:0] eight_color(input logic [2:0] idx);
		logic [3:0] c;
		case (idx)
			3'd0: c = 4'd0;
			3'd1: c = 4'd9;
			3'd2: c = 4'd12;
			3'd3: c = 4'd13;
			3'd4: c = 4'd10;
			3'd5: c = 4'd11;
			3'd6: c = 4'd14;
			default: c = 4'd15;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] palette_rgb(input logic [3:0] ci);
		logic [23:0] rgb;
		case (ci)
			4'd0:  rgb = {8'd0,   8'd0,   8'd0};
			4'd1:  rgb = {8'd160, 8'd0,   8'd0};
			4'd2:  rgb = {8'd0,   8'd160, 8'd0};
			4'd3:  rgb = {8'd160, 8'd160, 8'd0};
			4'd4:  rgb = {8'd0,   8'd0,   8'd160};
			4'd5:  rgb = {8'd160, 8'd0,   8'd160};
			4'd6:  rgb = {8'd0,   8'd160, 8'd160};
			4'd7:  rgb = {8'd160, 8'd160, 8'd160};
			4'd8:  rgb = {8'd191, 8'd191, 8'd191};
			4'd9:  rgb = {8'd255, 8'd80,  8'd80};
			4'd10: rgb = {8'd80,  8'd255, 8'd80};
			4'd11: rgb = {8'd255, 8'd255, 8'd80};
			4'd12: rgb = {8'd80,  8'd80,  8'd255};
			4'd13: rgb = {8'd255, 8'd80,  8'd255};
			4'd14: rgb = {8'd80,  8'd255, 8'd255};
			default: rgb = {8'd255, 8'd255, 8'd255};
		endcase
		return rgb;
	endfunction

endpackage

>>> src/avpg_cfg.sv
// configuration registers of the pixel generator
module avpg_cfg
	import avpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_profile <= RST_PROFILE;
			cfg_q.wide_mode     <= 1'b0;
			cfg_q.blink_phase   <= 1'b0;
			cfg_q.user_color    <= {4{RST_USER_COLOR}};
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COLOR_PROFILE: cfg_q.color_profile <= profile_t'(cfg_data[1:0]);
				CFG_WIDE_MODE:     cfg_q.wide_mode     <= cfg_data[0];
				CFG_BLINK_PHASE:   cfg_q.blink_phase   <= cfg_data[0];
				CFG_USER_COLOR_0:  cfg_q.user_color[0] <= cfg_data;
				CFG_USER_COLOR_1:  cfg_q.user_color[1] <= cfg_data;
				CFG_USER_COLOR_2:  cfg_q.user_color[2] <= cfg_data;
				CFG_USER_COLOR_3:  cfg_q.user_color[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/avpg_attr.sv
// attribute color selection for one video byte
module avpg_attr
	import avpg_pkg::*;
(
	input  cfg_t       cfg,
	input  byte_item_t item,
	output logic [3:0] color
);

	logic [1:0] d;
	logic [1:0] c;
	logic [1:0] attr;

	assign d    = item.video_byte[7:6];
	assign c    = item.paired_byte[7:6];
	assign attr = cfg.wide_mode ? 2'd0 : d;

	always_comb begin
		case (cfg.color_profile)
			PROF_MONO: color = COLOR_WHITE;
			PROF_STANDARD: begin
				if (cfg.blink_phase && attr[1]) begin
					color = COLOR_BLACK;
				end else begin
					color = attr[0] ? COLOR_SILVER : COLOR_WHITE;
				end
			end
			PROF_USER:  color = cfg.user_color[attr];
			PROF_EIGHT: color = eight_color({~|(d & c), d | c});
			default:    color = COLOR_BLACK;
		endcase
	end

endmodule

>>> src/avpg_shift.sv
// byte holding register and pixel shifter
`include "attribute_video_pixel_generator_unit_macros.svh"
module avpg_shift
	import avpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] video_byte,
	input  logic [3:0] color,
	input  logic       wide_mode,
	input  logic       advance,
	output logic       emit,
	output pix_t       pix
);

	logic             valid_s1;
	logic [7:0]       bits_s1;
	logic [3:0]       color_s1;
	logic [CNT_W-1:0] rem_s1;
	logic             last;
	logic             accept;

	assign last     = (rem_s1 == '0);
	assign emit     = valid_s1 && advance;
	assign in_stall = valid_s1 && !(emit && last);
	assign accept   = in_valid && !in_stall;

	assign pix.color_index = bits_s1[0] ? color_s1 : COLOR_BLACK;
	assign pix.last_pixel  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			rem_s1   <= wide_mode ? LAST_WIDE : LAST_NARROW;
		end else if (emit) begin
			valid_s1 <= !last;
			rem_s1   <= rem_s1 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_s1  <= video_byte;
			color_s1 <= color;
		end else if (emit) begin
			bits_s1 <= {1'b0, bits_s1[7:1]};
		end
	end

	`AVPG_ASSERT_NEXT(a_load_count, clk, arst_n, accept,
		valid_s1 && (rem_s1 == LAST_NARROW || rem_s1 == LAST_WIDE),
		"byte loaded with bad pixel count")
	`AVPG_ASSERT_NEXT(a_hold_byte, clk, arst_n, emit && !last,
		valid_s1 && rem_s1 == $past(rem_s1) - 1'b1,
		"byte dropped before its last pixel")

endmodule

>>> src/avpg_out.sv
// palette lookup and result register
`include "attribute_video_pixel_generator_unit_macros.svh"
module avpg_out
	import avpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        emit,
	input  pix_t        pix,
	output logic        advance,
	output logic        out_valid,
	input  logic        out_stall,
	output pixel_item_t out_data
);

	logic        valid_q;
	pixel_item_t data_q;
	logic [23:0] rgb;

	assign advance = !valid_q || !out_stall;
	assign rgb     = palette_rgb(pix.color_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q.color_index <= pix.color_index;
			data_q.red         <= rgb[23:16];
			data_q.green       <= rgb[15:8];
			data_q.blue        <= rgb[7:0];
			data_q.last_pixel  <= pix.last_pixel;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	`AVPG_ASSERT_NOW(a_black_rgb, clk, arst_n, valid_q && data_q.color_index == COLOR_BLACK,
		data_q.red == 8'd0 && data_q.green == 8'd0 && data_q.blue == 8'd0,
		"black pixel with nonzero color")

endmodule

>>> src/attribute_video_pixel_generator_unit.sv
// top level of the attribute video pixel generator
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+----------------------------
//  byte in   | byte_valid   | byte_stall   | byte_data  (byte_item_t)
//  pixel out | pixel_valid  | pixel_stall  | pixel_data (pixel_item_t)
//  config    | cfg_we       | -            | cfg_index, cfg_data
//
//  one pixel per cycle while no pixel stall holds it: a byte gives 6 pixels in narrow mode, 8 in wide mode
//  the pixel shifter sets the rate; the next byte loads as the last pixel leaves
//  the first pixel of a taken byte passes the shifter register, then the output register
//  reset clears the valid flags and loads the register defaults
//  a pixel stall freezes the shifter and stalls the byte input
module attribute_video_pixel_generator_unit
	import avpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  byte_item_t            byte_data,
	output logic                  pixel_valid,
	input  logic                  pixel_stall,
	output pixel_item_t           pixel_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	logic [3:0] color;
	logic       advance;
	logic       emit;
	pix_t       pix;

	avpg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	avpg_attr u_attr (
		.cfg   (cfg),
		.item  (byte_data),
		.color (color)
	);

	avpg_shift u_shift (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (byte_valid),
		.in_stall   (byte_stall),
		.video_byte (byte_data.video_byte),
		.color      (color),
		.wide_mode  (cfg.wide_mode),
		.advance    (advance),
		.emit       (emit),
		.pix        (pix)
	);

	avpg_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.pix       (pix),
		.advance   (advance),
		.out_valid (pixel_valid),
		.out_stall (pixel_stall),
		.out_data  (pixel_data)
	);

endmodule

>>> verif/avpg_pixel_checker.sv
// pixel checker: predicts the pixels of each accepted byte and compares them on the output
`timescale 1ns / 1ps

module avpg_pixel_checker
	import avpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic                  byte_stall,
	input  byte_item_t            byte_data,
	input  logic                  pixel_valid,
	input  logic                  pixel_stall,
	input  pixel_item_t           pixel_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam logic [23:0] PALETTE [16] = '{
		24'h000000, 24'hA00000, 24'h00A000, 24'hA0A000,
		24'h0000A0, 24'hA000A0, 24'h00A0A0, 24'hA0A0A0,
		24'hBFBFBF, 24'hFF5050, 24'h50FF50, 24'hFFFF50,
		24'h5050FF, 24'hFF50FF, 24'h50FFFF, 24'hFFFFFF
	};

	localparam logic [3:0] COMBINED_COLOR [8] = '{
		4'd0, 4'd9, 4'd12, 4'd13, 4'd10, 4'd11, 4'd14, 4'd15
	};

	profile_t    profile;
	logic        wide;
	logic        blink;
	logic [3:0]  user_color [4];
	pixel_item_t expected_pixels [$];

	function automatic logic [3:0] attribute_color(input logic [1:0] attr);
		logic [3:0] col;
		case (profile)
			PROF_MONO: begin
				col = COLOR_WHITE;
			end
			PROF_STANDARD: begin
				if (blink && attr[1])
					col = COLOR_BLACK;
				else
					col = attr[0] ? COLOR_SILVER : COLOR_WHITE;
			end
			PROF_USER: begin
				col = user_color[attr];
			end
			default: begin
				col = COLOR_BLACK;
			end
		endcase
		return col;
	endfunction

	task automatic queue_byte_pixels(input byte_item_t it);
		logic [1:0]  d;
		logic [1:0]  c;
		logic [2:0]  sel;
		logic [3:0]  col;
		int          count;
		pixel_item_t px;
		d = it.video_byte[7:6];
		c = it.paired_byte[7:6];
		count = wide ? 8 : 6;
		if (profile == PROF_EIGHT) begin
			sel = {(d & c) == 2'b00, d | c};
			col = COMBINED_COLOR[sel];
		end else begin
			col = attribute_color(wide ? 2'd0 : d);
		end
		for (int k = 0; k < count; k++) begin
			px.color_index = it.video_byte[k] ? col : COLOR_BLACK;
			{px.red, px.green, px.blue} = PALETTE[px.color_index];
			px.last_pixel = (k == count - 1);
			expected_pixels.push_back(px);
		end
	endtask

	task automatic compare_pixel(input pixel_item_t got);
		pixel_item_t want;
		if (expected_pixels.size() == 0) begin
			$error("color_index: expected no item, actual %0d", got.color_index);
			fail_count++;
		end else begin
			want = expected_pixels.pop_front();
			if (got.color_index !== want.color_index) begin
				$error("color_index: expected %0d, actual %0d", want.color_index, got.color_index);
				fail_count++;
			end
			if (got.red !== want.red) begin
				$error("red: expected %0d, actual %0d", want.red, got.red);
				fail_count++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, actual %0d", want.green, got.green);
				fail_count++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, actual %0d", want.blue, got.blue);
				fail_count++;
			end
			if (got.last_pixel !== want.last_pixel) begin
				$error("last_pixel: expected %0d, actual %0d", want.last_pixel, got.last_pixel);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile = RST_PROFILE;
			wide = 1'b0;
			blink = 1'b0;
			for (int i = 0; i < 4; i++)
				user_color[i] = RST_USER_COLOR;
			expected_pixels.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_COLOR_PROFILE: profile = profile_t'(cfg_data[1:0]);
					CFG_WIDE_MODE:     wide = cfg_data[0];
					CFG_BLINK_PHASE:   blink = cfg_data[0];
					CFG_USER_COLOR_0:  user_color[0] = cfg_data;
					CFG_USER_COLOR_1:  user_color[1] = cfg_data;
					CFG_USER_COLOR_2:  user_color[2] = cfg_data;
					CFG_USER_COLOR_3:  user_color[3] = cfg_data;
					default: ;
				endcase
			end
			if (byte_valid && !byte_stall)
				queue_byte_pixels(byte_data);
			if (pixel_valid && !pixel_stall)
				compare_pixel(pixel_data);
			pending = expected_pixels.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// testbench top: byte stimulus, configuration phases, output stalls and verdict
`timescale 1ns / 1ps

module tb_top;
	import avpg_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	byte_item_t            byte_data = '0;
	logic                  pixel_valid;
	logic                  pixel_stall = 1'b0;
	pixel_item_t           pixel_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  no_idle = 1'b0;
	int                    fail_count;
	int                    pending;
	int                    quiet_cycles = 0;

	always #5 clk = ~clk;

	attribute_video_pixel_generator_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_data  (pixel_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	avpg_pixel_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_data  (pixel_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always @(negedge clk) begin
		pixel_stall <= !no_idle && ($urandom_range(0, 99) < 31);
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (pixel_valid && !pixel_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] vb, input logic [7:0] pb);
		while (!no_idle && $urandom_range(0, 99) < 31) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{video_byte: vb, paired_byte: pb};
		do
			@(posedge clk);
		while (byte_stall);
		@(negedge clk);
	endtask

	// lower valid and let every queued pixel come out
	task automatic drain_pixels();
		byte_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input cfg_idx_t idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_config(input profile_t prof, input logic wide, input logic blink,
			input logic [3:0] u0, input logic [3:0] u1, input logic [3:0] u2,
			input logic [3:0] u3);
		reg_write(CFG_COLOR_PROFILE, {2'b00, prof});
		reg_write(CFG_WIDE_MODE, {3'b000, wide});
		reg_write(CFG_BLINK_PHASE, {3'b000, blink});
		reg_write(CFG_USER_COLOR_0, u0);
		reg_write(CFG_USER_COLOR_1, u1);
		reg_write(CFG_USER_COLOR_2, u2);
		reg_write(CFG_USER_COLOR_3, u3);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: standard profile, narrow, no blink
		send_byte(8'h00, 8'hFF);
		send_byte(8'hFF, 8'h00);
		send_byte(8'h3F, 8'hC0);
		send_byte(8'h7F, 8'h3F);
		send_byte(8'hBF, 8'h80);
		send_byte(8'h55, 8'h40);
		send_byte(8'hAA, 8'h15);

		// blink blanks attributes 2 and 3
		drain_pixels();
		set_config(PROF_STANDARD, 1'b0, 1'b1, 4'd15, 4'd15, 4'd15, 4'd15);
		send_byte(8'h3F, 8'h00);
		send_byte(8'h7F, 8'h00);
		send_byte(8'hBF, 8'h00);
		send_byte(8'hFF, 8'h00);

		// wide mode ignores the attribute bits and the blink
		drain_pixels();
		set_config(PROF_STANDARD, 1'b1, 1'b1, 4'd15, 4'd15, 4'd15, 4'd15);
		send_byte(8'hFF, 8'h00);
		send_byte(8'hC3, 8'hC0);

		// eight-colour combinations of both bytes
		drain_pixels();
		set_config(PROF_EIGHT, 1'b0, 1'b0, 4'd15, 4'd15, 4'd15, 4'd15);
		send_byte(8'h3F, 8'h00);
		send_byte(8'h7F, 8'h80);
		send_byte(8'hFF, 8'hC0);
		send_byte(8'hBF, 8'h40);
		send_byte(8'hFF, 8'h00);
		send_byte(8'h3F, 8'hC0);

		drain_pixels();
		set_config(PROF_EIGHT, 1'b1, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0);
		send_byte(8'hFF, 8'h80);
		send_byte(8'h81, 8'hC0);

		drain_pixels();
		set_config(PROF_MONO, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0);
		send_byte(8'h96, 8'h00);

		drain_pixels();
		set_config(PROF_USER, 1'b0, 1'b1, 4'd0, 4'd5, 4'd10, 4'd15);
		send_byte(8'h3F, 8'h00);
		send_byte(8'h7F, 8'h00);
		send_byte(8'hBF, 8'h00);
		send_byte(8'hFF, 8'h00);

		for (int ph = 0; ph < 12; ph++) begin
			drain_pixels();
			if (ph == 0)
				set_config(PROF_MONO, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0);
			else if (ph == 1)
				set_config(PROF_EIGHT, 1'b1, 1'b1, 4'd15, 4'd15, 4'd15, 4'd15);
			else
				set_config(profile_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
			no_idle <= (ph == 4);
			for (int i = 0; i < 24; i++) begin
				if (ph == 6 && i == 12)
					drain_pixels();
				send_byte(8'($urandom), 8'($urandom));
			end
		end
		no_idle <= 1'b0;

		drain_pixels();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
